[rtl/d64t_pkg.sv]
// Shared types and constants for the decimal64 BID to text converter.
// Holds the control word layout, the microcode ROM and the conversion
// unit's control bundle; no dependencies.
package d64t_pkg;

  // Step addresses of the microprogram
  localparam logic [3:0] ST_WAIT = 4'd0;
  localparam logic [3:0] ST_CONV = 4'd1;
  localparam logic [3:0] ST_SIGN = 4'd2;
  localparam logic [3:0] ST_ZCHK = 4'd3;
  localparam logic [3:0] ST_SP0  = 4'd4;
  localparam logic [3:0] ST_SP1  = 4'd5;
  localparam logic [3:0] ST_SP2  = 4'd6;
  localparam logic [3:0] ST_ZERO = 4'd7;
  localparam logic [3:0] ST_DIG  = 4'd8;
  localparam logic [3:0] ST_EXPE = 4'd9;
  localparam logic [3:0] ST_XSGN = 4'd10;
  localparam logic [3:0] ST_XDIG = 4'd11;

  // Character source selects
  localparam logic [3:0] CS_NONE = 4'd0;
  localparam logic [3:0] CS_SIGN = 4'd1;
  localparam logic [3:0] CS_SP0  = 4'd2;
  localparam logic [3:0] CS_SP1  = 4'd3;
  localparam logic [3:0] CS_SP2  = 4'd4;
  localparam logic [3:0] CS_ZERO = 4'd5;
  localparam logic [3:0] CS_DIG  = 4'd6;
  localparam logic [3:0] CS_E    = 4'd7;
  localparam logic [3:0] CS_XSGN = 4'd8;
  localparam logic [3:0] CS_XDIG = 4'd9;

  // Last-flag modes
  localparam logic [1:0] L_NONE   = 2'd0;
  localparam logic [1:0] L_ALWAYS = 2'd1;
  localparam logic [1:0] L_CNT_Z  = 2'd2;

  // Jump conditions (false or C_NONE falls through to next)
  localparam logic [2:0] C_NONE     = 3'd0;
  localparam logic [2:0] C_IN_VALID = 3'd1;
  localparam logic [2:0] C_CNT_NZ   = 3'd2;
  localparam logic [2:0] C_SPECIAL  = 3'd3;
  localparam logic [2:0] C_ZERO     = 3'd4;

  // Counter operations
  localparam logic [2:0] CNT_HOLD    = 3'd0;
  localparam logic [2:0] CNT_DEC     = 3'd1;
  localparam logic [2:0] CNT_LD_CONV = 3'd2;
  localparam logic [2:0] CNT_LD_SIG  = 3'd3;
  localparam logic [2:0] CNT_LD_EXP  = 3'd4;

  // Conversion: 56 source bits, 4 per step
  localparam logic [3:0] CONV_LAST = 4'd13;
  // Exponent lane runs on the final three steps
  localparam logic [3:0] XCONV_START = 4'd2;

  // ASCII codes
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_E     = 7'h45;
  localparam logic [6:0] CH_I     = 7'h69;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_F     = 7'h66;

  // Format constants
  localparam logic [53:0] SIG_MAX  = 54'd9999999999999999;
  localparam logic [9:0]  EXP_BIAS = 10'd398;

  typedef struct packed {
    logic [3:0] csrc;
    logic [1:0] last;
    logic [2:0] cond;
    logic [3:0] target;
    logic [3:0] next;
    logic [2:0] cnt_op;
    logic       conv;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic xstep;
  } conv_ctl_t;

  // Microprogram: one control word per step
  function automatic ucode_t ucode_rom(input logic [3:0] pc);
    ucode_t w;
    w = '{csrc: CS_NONE, last: L_NONE, cond: C_IN_VALID, target: ST_CONV,
          next: ST_WAIT, cnt_op: CNT_LD_CONV, conv: 1'b0};
    unique case (pc)
      ST_WAIT: w = '{CS_NONE, L_NONE,   C_IN_VALID, ST_CONV, ST_WAIT, CNT_LD_CONV, 1'b0};
      ST_CONV: w = '{CS_NONE, L_NONE,   C_CNT_NZ,   ST_CONV, ST_SIGN, CNT_DEC,     1'b1};
      ST_SIGN: w = '{CS_SIGN, L_NONE,   C_SPECIAL,  ST_SP0,  ST_ZCHK, CNT_HOLD,    1'b0};
      ST_ZCHK: w = '{CS_NONE, L_NONE,   C_ZERO,     ST_ZERO, ST_DIG,  CNT_LD_SIG,  1'b0};
      ST_SP0:  w = '{CS_SP0,  L_NONE,   C_NONE,     ST_WAIT, ST_SP1,  CNT_HOLD,    1'b0};
      ST_SP1:  w = '{CS_SP1,  L_NONE,   C_NONE,     ST_WAIT, ST_SP2,  CNT_HOLD,    1'b0};
      ST_SP2:  w = '{CS_SP2,  L_ALWAYS, C_NONE,     ST_WAIT, ST_WAIT, CNT_HOLD,    1'b0};
      ST_ZERO: w = '{CS_ZERO, L_ALWAYS, C_NONE,     ST_WAIT, ST_WAIT, CNT_HOLD,    1'b0};
      ST_DIG:  w = '{CS_DIG,  L_NONE,   C_CNT_NZ,   ST_DIG,  ST_EXPE, CNT_DEC,     1'b0};
      ST_EXPE: w = '{CS_E,    L_NONE,   C_NONE,     ST_WAIT, ST_XSGN, CNT_HOLD,    1'b0};
      ST_XSGN: w = '{CS_XSGN, L_NONE,   C_NONE,     ST_WAIT, ST_XDIG, CNT_LD_EXP,  1'b0};
      ST_XDIG: w = '{CS_XDIG, L_CNT_Z,  C_CNT_NZ,   ST_XDIG, ST_WAIT, CNT_DEC,     1'b0};
      default: w = '{CS_NONE, L_NONE,   C_NONE,     ST_WAIT, ST_WAIT, CNT_HOLD,    1'b0};
    endcase
    return w;
  endfunction

endpackage

[rtl/d64t_bcd_conv.sv]
// Binary to BCD conversion unit: shift-add-3, four source bits per step,
// for the 54-bit significand and the 9-bit exponent magnitude.
// Depends on d64t_pkg (conv_ctl_t).
module d64t_bcd_conv (
  input  logic                clk,
  input  d64t_pkg::conv_ctl_t ctl,
  input  logic [53:0]         sig_in,
  input  logic [8:0]          xmag_in,
  output logic [63:0]         sig_bcd,
  output logic [11:0]         exp_bcd
);

  logic [55:0] src_r, src_nxt;
  logic [63:0] bcd_r, bcd_nxt;
  logic [11:0] xsrc_r, xsrc_nxt;
  logic [11:0] xbcd_r, xbcd_nxt;

  // Four dabble steps on 16 digits
  function automatic logic [63:0] dabble16(input logic [63:0] b, input logic [3:0] nib);
    logic [63:0] v;
    v = b;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < 16; d++) begin
        if (v[d*4 +: 4] >= 4'd5) v[d*4 +: 4] = v[d*4 +: 4] + 4'd3;
      end
      v = {v[62:0], nib[s]};
    end
    return v;
  endfunction

  // Four dabble steps on 3 digits
  function automatic logic [11:0] dabble3(input logic [11:0] b, input logic [3:0] nib);
    logic [11:0] v;
    v = b;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < 3; d++) begin
        if (v[d*4 +: 4] >= 4'd5) v[d*4 +: 4] = v[d*4 +: 4] + 4'd3;
      end
      v = {v[10:0], nib[s]};
    end
    return v;
  endfunction

  // Next-state of both lanes
  always_comb begin
    src_nxt  = src_r;
    bcd_nxt  = bcd_r;
    xsrc_nxt = xsrc_r;
    xbcd_nxt = xbcd_r;
    if (ctl.load) begin
      src_nxt  = {2'b00, sig_in};
      bcd_nxt  = '0;
      xsrc_nxt = {3'b000, xmag_in};
      xbcd_nxt = '0;
    end else begin
      if (ctl.step) begin
        bcd_nxt = dabble16(bcd_r, src_r[55:52]);
        src_nxt = {src_r[51:0], 4'b0000};
      end
      if (ctl.xstep) begin
        xbcd_nxt = dabble3(xbcd_r, xsrc_r[11:8]);
        xsrc_nxt = {xsrc_r[7:0], 4'b0000};
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    bcd_r  <= bcd_nxt;
    xsrc_r <= xsrc_nxt;
    xbcd_r <= xbcd_nxt;
  end

  assign sig_bcd = bcd_r;
  assign exp_bcd = xbcd_r;

endmodule

[rtl/decimal64_bid_to_text.sv]
// Top level: decimal64 BID pattern in, scientific text out, one ASCII
// character per word. Depends on d64t_pkg and d64t_bcd_conv.
//
//  channel | dir | tdata                      | tuser | tlast
//  in_     | in  | [63:0] value_bits          | -     | -
//  out_    | out | [6:0] out_char, [7] zero   | -     | last_char
//
// An item takes one accept step, 14 conversion steps of the shift-add-3 unit
// (four bits each), then one microcode step per character, plus a zero-check
// step after the sign unless the value is inf/nan. Output stalls hold the
// sequencer on its current character step. rst_n is synchronous and returns
// the sequencer to its wait step with the output empty.
module decimal64_bid_to_text (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] out_char, [7] zero fill
  output logic        out_tlast   // last_char
);

  logic [3:0] pc_r, pc_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  d64t_pkg::ucode_t    cw;
  d64t_pkg::conv_ctl_t conv_ctl;

  logic        in_acc;
  logic        emit, slot_free, adv, cond_true;
  logic        sign_r, special_r, nan_r, zero_r, xneg_r;
  logic        last_bit;
  logic [6:0]  ch;
  logic [63:0] sig_bcd;
  logic [11:0] exp_bcd;
  logic [3:0]  sig_top, exp_top, sdig, xdig;
  logic        out_valid_r;
  logic [6:0]  out_char_r;
  logic        out_last_r;

  // Input decode
  logic        d_long, d_special, d_zero, d_xneg;
  logic [53:0] d_sig;
  logic [9:0]  d_exp;
  logic [9:0]  d_xmag;

  // long-exponent form: implicit 100 ahead of 51 stored bits, exponent in [60:51]
  assign d_long    = (in_tdata[62:61] == 2'b11);
  assign d_special = (in_tdata[62:59] == 4'b1111);
  assign d_sig     = d_long ? {3'b100, in_tdata[50:0]} : {1'b0, in_tdata[52:0]};
  assign d_zero    = (d_sig == '0) || (d_sig > d64t_pkg::SIG_MAX);
  assign d_exp     = d_long ? in_tdata[60:51] : in_tdata[62:53];
  assign d_xneg    = (d_exp < d64t_pkg::EXP_BIAS);
  assign d_xmag    = d_xneg ? (d64t_pkg::EXP_BIAS - d_exp) : (d_exp - d64t_pkg::EXP_BIAS);

  // Control word fetch and step handshake
  assign cw        = d64t_pkg::ucode_rom(pc_r);
  assign emit      = (cw.csrc != d64t_pkg::CS_NONE);
  assign slot_free = !out_valid_r || out_tready;
  assign adv       = !emit || slot_free;
  assign in_tready = (pc_r == d64t_pkg::ST_WAIT);
  assign in_acc    = in_tvalid && in_tready;

  // Jump condition
  always_comb begin
    unique case (cw.cond)
      d64t_pkg::C_IN_VALID: cond_true = in_tvalid;
      d64t_pkg::C_CNT_NZ:   cond_true = (cnt_r != 4'd0);
      d64t_pkg::C_SPECIAL:  cond_true = special_r;
      d64t_pkg::C_ZERO:     cond_true = zero_r;
      default:              cond_true = 1'b0;
    endcase
  end

  assign pc_nxt = adv ? (cond_true ? cw.target : cw.next) : pc_r;

  // Highest nonzero digit positions
  always_comb begin
    sig_top = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (sig_bcd[i*4 +: 4] != 4'd0) sig_top = 4'(i);
    end
    exp_top = 4'd0;
    for (int i = 0; i < 3; i++) begin
      if (exp_bcd[i*4 +: 4] != 4'd0) exp_top = 4'(i);
    end
  end

  // Step counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (adv) begin
      unique case (cw.cnt_op)
        d64t_pkg::CNT_DEC:     cnt_nxt = cnt_r - 4'd1;
        d64t_pkg::CNT_LD_CONV: cnt_nxt = d64t_pkg::CONV_LAST;
        d64t_pkg::CNT_LD_SIG:  cnt_nxt = sig_top;
        d64t_pkg::CNT_LD_EXP:  cnt_nxt = exp_top;
        default:               cnt_nxt = cnt_r;
      endcase
    end
  end

  // Conversion unit
  assign conv_ctl.load  = in_acc;
  assign conv_ctl.step  = adv && cw.conv;
  assign conv_ctl.xstep = adv && cw.conv && (cnt_r <= d64t_pkg::XCONV_START);

  d64t_bcd_conv u_conv (
    .clk     (clk),
    .ctl     (conv_ctl),
    .sig_in  (d_sig),
    .xmag_in (d_xmag[8:0]),
    .sig_bcd (sig_bcd),
    .exp_bcd (exp_bcd)
  );

  // Digit pick
  assign sdig = sig_bcd[{cnt_r, 2'b00} +: 4];
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    xdig = exp_bcd[3:0];
      2'd1:    xdig = exp_bcd[7:4];
      2'd2:    xdig = exp_bcd[11:8];
      default: xdig = 4'd0;
    endcase
  end

  // Character select
  always_comb begin
    unique case (cw.csrc)
      d64t_pkg::CS_SIGN: ch = sign_r ? d64t_pkg::CH_MINUS : d64t_pkg::CH_PLUS;
      d64t_pkg::CS_SP0:  ch = nan_r ? d64t_pkg::CH_N : d64t_pkg::CH_I;
      d64t_pkg::CS_SP1:  ch = nan_r ? d64t_pkg::CH_A : d64t_pkg::CH_N;
      d64t_pkg::CS_SP2:  ch = nan_r ? d64t_pkg::CH_N : d64t_pkg::CH_F;
      d64t_pkg::CS_ZERO: ch = d64t_pkg::CH_ZERO;
      d64t_pkg::CS_DIG:  ch = d64t_pkg::CH_ZERO | {3'b000, sdig};
      d64t_pkg::CS_E:    ch = d64t_pkg::CH_E;
      d64t_pkg::CS_XSGN: ch = xneg_r ? d64t_pkg::CH_MINUS : d64t_pkg::CH_PLUS;
      d64t_pkg::CS_XDIG: ch = d64t_pkg::CH_ZERO | {3'b000, xdig};
      default:           ch = 7'h00;
    endcase
  end

  always_comb begin
    unique case (cw.last)
      d64t_pkg::L_ALWAYS: last_bit = 1'b1;
      d64t_pkg::L_CNT_Z:  last_bit = (cnt_r == 4'd0);
      default:            last_bit = 1'b0;
    endcase
  end

  // Sequencer and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= d64t_pkg::ST_WAIT;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
      if (emit && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and decoded flags
  always_ff @(posedge clk) begin
    if (emit && slot_free) begin
      out_char_r <= ch;
      out_last_r <= last_bit;
    end
    if (in_acc) begin
      sign_r    <= in_tdata[63];
      special_r <= d_special;
      nan_r     <= in_tdata[58];
      zero_r    <= d_zero;
      xneg_r    <= d_xneg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // An accepted word always starts the conversion loop
  a_acc_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> pc_r == d64t_pkg::ST_CONV)
    else $error("accepted word did not start conversion");

  // Digit characters are decimal
  a_digit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:4] == 3'h3 |-> out_tdata[3:0] <= 4'd9)
    else $error("non-decimal digit emitted");

  // Exponent never has more than three digits
  a_xcnt: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == d64t_pkg::ST_XDIG |-> cnt_r <= 4'd2)
    else $error("exponent digit count out of range");
`endif

endmodule
